@@ rtl/core/bids_pkg.sv @@
package bids_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned CPOS_W  = 30;
  localparam int unsigned RPOS_W  = 32;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DEF_MAX_LINE = 4096;
  localparam int unsigned DEF_LANES    = 4;
  localparam int unsigned MAX_RUN = 4;

  // register indexes
  localparam logic [2:0] REG_SRC_W   = 3'd0;
  localparam logic [2:0] REG_SRC_H   = 3'd1;
  localparam logic [2:0] REG_DST_W   = 3'd2;
  localparam logic [2:0] REG_DST_H   = 3'd3;
  localparam logic [2:0] REG_CSTEP   = 3'd4;
  localparam logic [2:0] REG_RSTEP   = 3'd5;
  localparam logic [2:0] REG_NCH     = 3'd6;

  typedef logic [4*PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [WGT_W-1:0] tl;
    logic [WGT_W-1:0] tr;
    logic [WGT_W-1:0] bl;
    logic [WGT_W-1:0] br;
  } wgt_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

@@ rtl/core/bids_if.sv @@
interface bids_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic [7:0] chan_d;
  modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface bids_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_a;
  logic [7:0]  out_b;
  logic [7:0]  out_c;
  logic [7:0]  out_d;
  logic [11:0] out_col;
  logic [13:0] out_row;
  logic        run_last;
  logic        frame_end;
  modport source (output valid, out_a, out_b, out_c, out_d, out_col, out_row,
                  run_last, frame_end, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, out_col, out_row,
                  run_last, frame_end, output ready);
endinterface

@@ rtl/core/bids_lane.sv @@
module bids_lane (
  input  logic [7:0]    px_tl,
  input  logic [7:0]    px_tr,
  input  logic [7:0]    px_bl,
  input  logic [7:0]    px_br,
  input  bids_pkg::wgt_t wgt,
  input  logic          en,
  output logic [7:0]    res
);
  import bids_pkg::*;

  logic [25:0] sum;
  logic [9:0]  rnd;

  always_comb begin
    sum = 26'(px_tl) * 26'(wgt.tl) + 26'(px_tr) * 26'(wgt.tr)
        + 26'(px_bl) * 26'(wgt.bl) + 26'(px_br) * 26'(wgt.br) + 26'd32768;
    rnd = sum[25:16];
    if (!en) begin
      res = 8'd0;
    end else if (rnd > 10'd255) begin
      res = 8'd255;
    end else begin
      res = rnd[7:0];
    end
  end

endmodule

@@ rtl/core/bilinear_image_downscaler_unit.sv @@
// Streaming bilinear downscaler. Source pixels enter in raster order on
// in_ch, one transfer per pixel; each source pixel yields zero to four
// destination pixels on out_ch, the last one flagged run_last, the final
// pixel of the image flagged frame_end. Each source pixel passes through the
// states in order: ST_IDLE accepts the transfer and reads the line store;
// then per result ST_CALC picks neighbours and forms the weight products and
// ST_MUL runs the per-channel lane multiply-accumulate, waiting while the
// output stalls; a neighbour check in ST_CALC that finds nothing to emit
// is a step of its own. ST_FIN writes the line store and steps the source
// counters. LANES channel lanes run side by side; their bytes are merged
// into one output register. Steps are Q13.16 (column) and Q15.16 (row),
// written by software (>= 1.0). The line store holds MAX_LINE pixels and
// needs no clearing after reset.
module bilinear_image_downscaler_unit #(
  parameter int unsigned MAX_LINE = bids_pkg::DEF_MAX_LINE,
  parameter int unsigned LANES    = bids_pkg::DEF_LANES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bids_in_if.sink                   in_ch,
  bids_out_if.source                out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [bids_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bids_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bids_pkg::DATA_W-1:0] cfg_prdata,
  output logic                      cfg_pready
);
  import bids_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned SW = $clog2(MAX_LINE + 1);

  // configuration registers
  logic [12:0] src_w_r, dst_w_r;
  logic [14:0] src_h_r, dst_h_r;
  logic [28:0] cstep_r;
  logic [30:0] rstep_r;
  logic [2:0]  nch_r;

  wire cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 13'd1;
      src_h_r <= 15'd1;
      dst_w_r <= 13'd1;
      dst_h_r <= 15'd1;
      cstep_r <= 29'd65536;
      rstep_r <= 31'd65536;
      nch_r   <= 3'd3;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_SRC_W: src_w_r <= cfg_pwdata[12:0];
        REG_SRC_H: src_h_r <= cfg_pwdata[14:0];
        REG_DST_W: dst_w_r <= cfg_pwdata[12:0];
        REG_DST_H: dst_h_r <= cfg_pwdata[14:0];
        REG_CSTEP: cstep_r <= cfg_pwdata[28:0];
        REG_RSTEP: rstep_r <= cfg_pwdata[30:0];
        REG_NCH:   nch_r   <= cfg_pwdata[2:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_SRC_W: cfg_prdata = 32'(src_w_r);
      REG_SRC_H: cfg_prdata = 32'(src_h_r);
      REG_DST_W: cfg_prdata = 32'(dst_w_r);
      REG_DST_H: cfg_prdata = 32'(dst_h_r);
      REG_CSTEP: cfg_prdata = 32'(cstep_r);
      REG_RSTEP: cfg_prdata = 32'(rstep_r);
      REG_NCH:   cfg_prdata = 32'(nch_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // effective sizes: zero counts as one, large values saturate
  logic [SW-1:0] sw;
  logic [14:0]   sh, th;
  logic [12:0]   tw;
  always_comb begin
    if (src_w_r == '0) sw = SW'(1);
    else if (32'(src_w_r) > MAX_LINE) sw = SW'(MAX_LINE);
    else sw = SW'(src_w_r);
    sh = (src_h_r == '0) ? 15'd1 : (src_h_r > 15'd16384 ? 15'd16384 : src_h_r);
    th = (dst_h_r == '0) ? 15'd1 : (dst_h_r > 15'd16384 ? 15'd16384 : dst_h_r);
    tw = (dst_w_r == '0) ? 13'd1 : (dst_w_r > 13'd4096 ? 13'd4096 : dst_w_r);
  end

  // datapath state
  state_t          state_r;
  logic [AW-1:0]   sc_r;
  logic [ROW_W-1:0] sr_r;
  logic [12:0]     dc_r;
  logic [14:0]     dr_r;
  logic [CPOS_W-1:0] cpos_r;
  logic [RPOS_W-1:0] rpos_r;
  logic            done_r;
  logic [2:0]      n_r;
  pix_t            cur_r, left_r, abl_r, rd_r;

  // line store
  pix_t mem [MAX_LINE];
  wire in_xfer = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_xfer) rd_r <= mem[sc_r];
    if (state_r == ST_FIN) mem[sc_r] <= cur_r;
  end

  // neighbour positions of the next pending destination pixel
  logic [14:0] x0, x1;
  logic [16:0] y0, y1;
  logic        use_left, use_up, elig, cand;
  always_comb begin
    x0 = 15'(cpos_r[29:16]);
    x1 = (x0 + 15'd1 < 15'(sw)) ? x0 + 15'd1 : 15'(sw) - 15'd1;
    y0 = 17'(rpos_r[31:16]);
    y1 = (y0 + 17'd1 < 17'(sh)) ? y0 + 17'd1 : 17'(sh) - 17'd1;
    use_left = x0 < x1;
    use_up   = y0 < y1;
    elig = (y1 < 17'(sr_r)) || (y1 == 17'(sr_r) && x1 <= 15'(sc_r));
    cand = !done_r && elig;
  end

  pix_t p_tl, p_tr, p_bl;
  logic [WGT_W-1:0] fx, fy;
  always_comb begin
    p_tr = use_up ? rd_r : cur_r;
    p_bl = use_left ? left_r : cur_r;
    p_tl = use_up ? (use_left ? abl_r : rd_r) : (use_left ? left_r : cur_r);
    fx = WGT_W'(cpos_r[15:8]);
    fy = WGT_W'(rpos_r[15:8]);
  end

  // result pipeline registers
  pix_t            q_tl_r, q_tr_r, q_bl_r, q_br_r;
  wgt_t            wgt_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic            fend_r;

  wire [12:0] dc_inc = dc_r + 13'd1;
  wire [14:0] dr_inc = dr_r + 15'd1;
  wire        out_free = !out_ch.valid || out_ch.ready;
  wire        last_run = (n_r == 3'(MAX_RUN)) || !cand;

  // lanes and merge
  logic [7:0] lane_res [4];
  genvar j;
  generate
    for (j = 0; j < 4; j++) begin : g_lane
      if (j < LANES) begin : g_on
        bids_lane u_lane (
          .px_tl (q_tl_r[8*j +: 8]),
          .px_tr (q_tr_r[8*j +: 8]),
          .px_bl (q_bl_r[8*j +: 8]),
          .px_br (q_br_r[8*j +: 8]),
          .wgt   (wgt_r),
          .en    (32'(j) < 32'(nch_r)),
          .res   (lane_res[j])
        );
      end else begin : g_off
        assign lane_res[j] = 8'd0;
      end
    end
  endgenerate

  logic out_valid_r;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL && out_free) begin
      out_ch.out_a     <= lane_res[0];
      out_ch.out_b     <= lane_res[1];
      out_ch.out_c     <= lane_res[2];
      out_ch.out_d     <= lane_res[3];
      out_ch.out_col   <= col_r;
      out_ch.out_row   <= row_r;
      out_ch.run_last  <= last_run;
      out_ch.frame_end <= fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sc_r   <= '0;
      sr_r   <= '0;
      dc_r   <= '0;
      dr_r   <= '0;
      cpos_r <= '0;
      rpos_r <= '0;
      done_r <= 1'b0;
      n_r    <= '0;
      left_r <= '0;
      abl_r  <= '0;
    end else begin
      // output register: load a new result, else drop after its transfer
      if (state_r == ST_MUL && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            cur_r   <= {in_ch.chan_d, in_ch.chan_c, in_ch.chan_b, in_ch.chan_a};
            n_r     <= '0;
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (cand) begin
            q_tl_r <= p_tl;
            q_tr_r <= p_tr;
            q_bl_r <= p_bl;
            q_br_r <= cur_r;
            wgt_r.tl <= (WGT_W'(256) - fx) * (WGT_W'(256) - fy);
            wgt_r.tr <= fx * (WGT_W'(256) - fy);
            wgt_r.bl <= (WGT_W'(256) - fx) * fy;
            wgt_r.br <= fx * fy;
            col_r  <= dc_r[COL_W-1:0];
            row_r  <= dr_r[ROW_W-1:0];
            fend_r <= 1'b0;
            n_r    <= n_r + 3'd1;
            if (dc_inc >= tw) begin
              dc_r   <= '0;
              cpos_r <= '0;
              dr_r   <= dr_inc;
              rpos_r <= rpos_r + RPOS_W'(rstep_r);
              if (dr_inc >= th) begin
                done_r <= 1'b1;
                fend_r <= 1'b1;
              end
            end else begin
              dc_r   <= dc_inc;
              cpos_r <= cpos_r + CPOS_W'(cstep_r);
            end
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_MUL: begin
          if (out_free) begin
            state_r <= last_run ? ST_FIN : ST_CALC;
          end
        end
        ST_FIN: begin
          abl_r  <= rd_r;
          left_r <= cur_r;
          if (SW'(sc_r) >= sw - SW'(1)) begin
            sc_r <= '0;
            if (15'(sr_r) >= sh - 15'd1) begin
              sr_r   <= '0;
              dc_r   <= '0;
              dr_r   <= '0;
              cpos_r <= '0;
              rpos_r <= '0;
              done_r <= 1'b0;
            end else begin
              sr_r <= sr_r + ROW_W'(1);
            end
          end else begin
            sc_r <= sc_r + AW'(1);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sim/bids_scoreboard.sv @@
`timescale 1ns / 100ps

module bids_scoreboard (
  input  logic  clk,
  input  logic  rst_n,
  bids_in_if    in_mon,
  bids_out_if   out_mon,
  input  logic  cfg_psel,
  input  logic  cfg_penable,
  input  logic  cfg_pwrite,
  input  logic  cfg_pready,
  input  logic [bids_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bids_pkg::DATA_W-1:0] cfg_pwdata,
  output int    fail_count,
  output int    pending
);
  import bids_pkg::*;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [11:0] col;
    logic [13:0] row;
    logic        last;
    logic        fend;
  } dst_pix_t;

  // implemented bits of each register
  localparam logic [31:0] REG_MASK [7] = '{
    32'h0000_1FFF, 32'h0000_7FFF, 32'h0000_1FFF, 32'h0000_7FFF,
    32'h1FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0007
  };

  dst_pix_t   dst_queue[$];
  logic [31:0] regs [7];
  pix_t        line_mem [DEF_MAX_LINE];
  pix_t        left_px, above_left_px;
  int unsigned src_col, src_row, dst_col, dst_row;
  logic [29:0] col_pos;
  logic [31:0] row_pos;
  logic        image_done;

  assign pending = dst_queue.size();

  function automatic int unsigned fit_size(logic [31:0] v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic string show(dst_pix_t p);
    return $sformatf("a=%0d b=%0d c=%0d d=%0d col=%0d row=%0d last=%0b end=%0b",
                     p.a, p.b, p.c, p.d, p.col, p.row, p.last, p.fend);
  endfunction

  // Interpolate up to MAX_RUN destination pixels whose lower-right neighbour is now in.
  task automatic take_pixel(pix_t cur);
    int unsigned sw, sh, tw, th, idx, x0, y0, x1, y1, fx, fy, n, j, s, v;
    int unsigned w_tl, w_tr, w_bl, w_br;
    pix_t above, p_tl, p_tr, p_bl, p_br;
    logic use_left, use_up;
    dst_pix_t r;
    sw = fit_size(regs[REG_SRC_W], DEF_MAX_LINE);
    sh = fit_size(regs[REG_SRC_H], 16384);
    tw = fit_size(regs[REG_DST_W], 4096);
    th = fit_size(regs[REG_DST_H], 16384);
    idx = (src_col < DEF_MAX_LINE) ? src_col : DEF_MAX_LINE - 1;
    above = line_mem[idx];
    n = 0;
    while (n < MAX_RUN && !image_done) begin
      x0 = 32'(col_pos >> 16);
      y0 = row_pos >> 16;
      x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
      if (!(y1 < src_row || (y1 == src_row && x1 <= src_col))) break;
      use_left = x0 < x1;
      use_up = y0 < y1;
      p_br = cur;
      p_tr = use_up ? above : cur;
      p_bl = use_left ? left_px : cur;
      p_tl = use_up ? (use_left ? above_left_px : above) : (use_left ? left_px : cur);
      fx = 32'(col_pos[15:8]);
      fy = 32'(row_pos[15:8]);
      w_tl = (256 - fx) * (256 - fy);
      w_tr = fx * (256 - fy);
      w_bl = (256 - fx) * fy;
      w_br = fx * fy;
      r = '0;
      for (j = 0; j < 4; j++) begin
        v = 0;
        if (j < regs[REG_NCH]) begin
          s = p_tl[8*j +: 8] * w_tl + p_tr[8*j +: 8] * w_tr
            + p_bl[8*j +: 8] * w_bl + p_br[8*j +: 8] * w_br;
          v = (s + 32768) >> 16;
          if (v > 255) v = 255;
        end
        case (j)
          0: r.a = 8'(v);
          1: r.b = 8'(v);
          2: r.c = 8'(v);
          default: r.d = 8'(v);
        endcase
      end
      r.col = 12'(dst_col);
      r.row = 14'(dst_row);
      dst_col++;
      col_pos = col_pos + regs[REG_CSTEP][29:0];
      if (dst_col >= tw) begin
        dst_col = 0;
        col_pos = 0;
        dst_row++;
        row_pos = row_pos + regs[REG_RSTEP];
        if (dst_row >= th) begin
          image_done = 1'b1;
          r.fend = 1'b1;
        end
      end
      dst_queue.insert(dst_queue.size(), r);
      n++;
    end
    if (n > 0) dst_queue[$].last = 1'b1;
    above_left_px = above;
    left_px = cur;
    line_mem[idx] = cur;
    if (src_col >= sw - 1) begin
      src_col = 0;
      if (src_row >= sh - 1) begin
        src_row = 0;
        dst_col = 0;
        dst_row = 0;
        col_pos = 0;
        row_pos = 0;
        image_done = 1'b0;
      end else begin
        src_row++;
      end
    end else begin
      src_col++;
    end
  endtask

  always @(posedge clk) begin
    dst_pix_t act, exp_px;
    if (!rst_n) begin
      regs[REG_SRC_W] = 1;
      regs[REG_SRC_H] = 1;
      regs[REG_DST_W] = 1;
      regs[REG_DST_H] = 1;
      regs[REG_CSTEP] = 65536;
      regs[REG_RSTEP] = 65536;
      regs[REG_NCH] = 3;
      left_px = '0;
      above_left_px = '0;
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
      col_pos = 0;
      row_pos = 0;
      image_done = 1'b0;
      dst_queue.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        act = {out_mon.out_a, out_mon.out_b, out_mon.out_c, out_mon.out_d,
               out_mon.out_col, out_mon.out_row, out_mon.run_last, out_mon.frame_end};
        if (dst_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %s", $time, show(act));
          fail_count++;
        end else begin
          exp_px = dst_queue.pop_front();
          if (act !== exp_px) begin
            $display("%0t: mismatch, expected %s, actual %s", $time, show(exp_px), show(act));
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        take_pixel({in_mon.chan_d, in_mon.chan_c, in_mon.chan_b, in_mon.chan_a});
      // register write lands at the access phase
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[4:2] <= REG_NCH)
        regs[cfg_paddr[4:2]] = cfg_pwdata & REG_MASK[cfg_paddr[4:2]];
    end
  end

endmodule

@@ sim/bilinear_image_downscaler_unit_test.sv @@
`timescale 1ns / 100ps

module bilinear_image_downscaler_unit_test;
  import bids_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  int   fail_count, pending;

  // traffic shaping, shared with the receiver process
  logic steady = 1'b0;       // no random gaps on either side
  logic hold_req = 1'b0;     // receiver blocks for a long stretch
  int   random_items = 0;

  bids_in_if  in_ch ();
  bids_out_if out_ch ();

  always #4 clk = ~clk;

  bilinear_image_downscaler_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  bids_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.chan_a = '0;
    in_ch.chan_b = '0;
    in_ch.chan_c = '0;
    in_ch.chan_d = '0;
    out_ch.ready = 1'b0;
  end

  // Result receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  // Run ends here regardless, if the block hangs.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Stop offering, drain, let a no-result pixel finish, then program all registers.
  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned cstep, int unsigned rstep,
                              int unsigned nch);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    reg_write(REG_SRC_W, sw);
    reg_write(REG_SRC_H, sh);
    reg_write(REG_DST_W, tw);
    reg_write(REG_DST_H, th);
    reg_write(REG_CSTEP, cstep);
    reg_write(REG_RSTEP, rstep);
    reg_write(REG_NCH, nch);
  endtask

  // One source pixel transfer; valid is left high afterwards for the next one.
  task automatic send_pixel(logic [31:0] px);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.chan_d, in_ch.chan_c, in_ch.chan_b, in_ch.chan_a} <= px;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic int unsigned eff(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Whole source frames only, so width changes never fall mid-frame.
  task automatic send_frames(int unsigned sw, int unsigned sh, int unsigned frames);
    int unsigned total;
    total = eff(sw, DEF_MAX_LINE) * eff(sh, 16384) * frames;
    repeat (total) send_pixel($urandom);
  endtask

  initial begin
    int unsigned sw, sh, tw, th, cs, rs, nch, frames, phase;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: 1x1 copy, both sample extremes
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);

    // 4x3 -> 2x2 at a fractional row step, all four lanes, extreme samples
    set_geometry(4, 3, 2, 2, 32'h0002_0000, 32'h0001_8000, 4);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFF00_FF00);
    send_pixel(32'h00FF_00FF);
    repeat (8) send_pixel($urandom);

    // target as large as source: clamped right/bottom neighbours, late pixels
    set_geometry(3, 2, 3, 2, 32'h0001_4000, 32'h0001_C000, 1);
    send_frames(3, 2, 1);

    // zero sizes count as one; channel count beyond the lanes
    set_geometry(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 7);
    send_frames(1, 1, 2);

    // maximum column step, destination rows far past the source (dropped at wrap)
    set_geometry(5, 2, 3, 32'h7FFF, 32'h1FFF_FFFF, 32'h0001_0000, 2);
    send_frames(5, 2, 2);

    phase = 0;
    while (random_items < 440) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 8);
      // the held-off phase gets a large frame so the block backs up
      if (phase == 2) begin
        sw = 12;
        sh = 8;
      end
      tw = $urandom_range(1, sw + 2);
      th = $urandom_range(1, sh + 2);
      cs = $urandom_range(65536, ((sw << 16) / tw) + 32768);
      rs = $urandom_range(65536, ((sh << 16) / th) + 32768);
      nch = $urandom_range(0, 7);
      frames = $urandom_range(1, 2);
      set_geometry(sw, sh, tw, th, cs, rs, nch);
      steady = (phase == 1);
      if (phase == 2) hold_req = 1'b1;
      send_frames(sw, sh, frames);
      random_items += sw * sh * frames;
      phase++;
    end
    steady = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    fork
      wait (pending == 0);
      repeat (200_000) @(posedge clk);
    join_any
    disable fork;
    repeat (50) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      if (pending != 0)
        $display("%0t: %0d expected results never arrived", $time, pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bids_pkg.sv
rtl/core/bids_if.sv
rtl/core/bids_lane.sv
rtl/core/bilinear_image_downscaler_unit.sv
sim/bids_scoreboard.sv
sim/bilinear_image_downscaler_unit_test.sv
